FILE: design/tsfu_pkg.sv
// Shared types, constants and helpers for the six-function trigonometry unit.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package tsfu_pkg;

   localparam int SERIES_TERMS = 24;
   localparam int TERM_COUNT   = 2 * SERIES_TERMS + 1;
   localparam int TERM_IDX_W   = $clog2(TERM_COUNT + 1);
   localparam int FRAC_BITS    = 52;
   localparam int TERM_STAGES  = 5;
   localparam int FRONT_STAGES = 2;
   localparam int DIV_STEPS    = 47;
   localparam int DIV_LAT      = DIV_STEPS + 2;
   localparam int TOTAL_LAT    = FRONT_STAGES + TERM_COUNT * TERM_STAGES + 2 + DIV_LAT + 1;

   localparam logic signed [16:0] ANGLE_LIMIT = 17'sd46080;
   localparam int RAD_W = 40;
   localparam logic [127:0] RAD_SCALE_FULL =
      (128'd314159 << FRAC_BITS) / (128'd100000 * 128'd23040);
   localparam logic [RAD_W-1:0] RAD_SCALE = RAD_SCALE_FULL[RAD_W-1:0];

   localparam logic [30:0] RATIO_MAX = 31'h7FFF_FFFF;
   localparam logic signed [31:0] Q30_ONE = 32'sd1073741824;
   localparam logic [63:0] ONE_Q52 = 64'd1 << FRAC_BITS;

   localparam logic [1:0] CLS_COS_ADD = 2'd0;
   localparam logic [1:0] CLS_SIN_ADD = 2'd1;
   localparam logic [1:0] CLS_COS_SUB = 2'd2;
   localparam logic [1:0] CLS_SIN_SUB = 2'd3;

   typedef struct packed {
      logic               valid;
      logic               neg;
      logic [63:0]        x;
      logic [63:0]        t;
      logic signed [63:0] s_sin;
      logic signed [63:0] s_cos;
   } lane_type;

   // fold the term in l.t, of class k (its index mod 4), into the running sums
   function automatic lane_type accum(input lane_type l, input logic [1:0] k);
      lane_type r;
      r = l;
      unique case (k)
         CLS_COS_ADD: r.s_cos = l.s_cos + $signed(l.t);
         CLS_SIN_ADD: r.s_sin = l.s_sin + $signed(l.t);
         CLS_COS_SUB: r.s_cos = l.s_cos - $signed(l.t);
         CLS_SIN_SUB: r.s_sin = l.s_sin - $signed(l.t);
         default:     r = l;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

FILE: design/trig_six_function_unit_top.sv
// Top level of the six-function trigonometry unit: front end, Taylor term
// chain and ratio back end. Depends on tsfu_pkg and all tsfu_ modules.
//
// Input channel: a beat is taken at a rising edge with start high and busy
// low; req_angle_deg is a signed angle in 1/128 degree, clamped to +-360.
// Result channel: rsp_valid marks each result beat for exactly one cycle;
// the receiver takes it at the edge that ends that cycle and cannot stall.
// Results: sine and cosine in Q2.30; tangent, cotangent, cosecant and secant
// in Q16.16, saturated to +-(2^31-1); rsp_ratio_status flags any saturation.
// Throughput: one angle per clock while busy is low, fully pipelined.
// Pipeline: a beat passes 2 front stages, 5 stages for each of the 49 series
// terms, 2 for the last sum and Q2.30 rounding, 49 for the bit-per-stage
// dividers and one result register.
// Reset: synchronous; busy is high while reset is applied and every beat in
// flight is dropped. The block keeps no other state.
`timescale 1ns / 1ps
`default_nettype none
module trig_six_function_unit_top import tsfu_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [16:0] req_angle_deg,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_sine_value,
   output logic signed [31:0] rsp_cosine_value,
   output logic signed [31:0] rsp_tangent_value,
   output logic signed [31:0] rsp_cotangent_value,
   output logic signed [31:0] rsp_cosecant_value,
   output logic signed [31:0] rsp_secant_value,
   output logic               rsp_ratio_status
);

   logic     accept;
   lane_type lanes [TERM_COUNT+1];

   assign busy   = reset;
   assign accept = start & ~busy;

   tsfu_front u_front (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .angle  (req_angle_deg),
      .lane_o (lanes[0])
   );

   for (genvar g = 0; g < TERM_COUNT; g++) begin : g_term
      localparam logic [127:0] TWO64 = 128'd1 << 64;
      localparam logic [127:0] RQ    = TWO64 / 128'(g + 1);
      localparam logic [63:0]  RECIP = (g == 0) ? 64'hFFFF_FFFF_FFFF_FFFF : RQ[63:0];
      tsfu_term u_term (
         .clock  (clock),
         .reset  (reset),
         .idx    (TERM_IDX_W'(g + 1)),
         .recip  (RECIP),
         .lane_i (lanes[g]),
         .lane_o (lanes[g+1])
      );
   end

   tsfu_ratio u_ratio (
      .clock     (clock),
      .reset     (reset),
      .lane_i    (lanes[TERM_COUNT]),
      .out_valid (rsp_valid),
      .out_sin   (rsp_sine_value),
      .out_cos   (rsp_cosine_value),
      .out_tan   (rsp_tangent_value),
      .out_cot   (rsp_cotangent_value),
      .out_csc   (rsp_cosecant_value),
      .out_sec   (rsp_secant_value),
      .out_sat   (rsp_ratio_status)
   );

`ifndef SYNTH
   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##TOTAL_LAT rsp_valid)
      else $error("result beat missing at fixed latency");

   a_sin_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_sine_value <= Q30_ONE) && (rsp_sine_value >= -Q30_ONE))
      else $error("sine out of Q2.30 range");

   a_zero_sin_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_sine_value == '0) |-> rsp_ratio_status)
      else $error("zero sine without saturation status");

   a_zero_cos_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_cosine_value == '0) |-> rsp_ratio_status)
      else $error("zero cosine without saturation status");
`endif

endmodule
`default_nettype wire

FILE: design/tsfu_front.sv
// Input stage: clamp the angle, take its magnitude and scale it to radians.
// Depends on tsfu_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tsfu_front import tsfu_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic signed [16:0] angle,
   output lane_type           lane_o
);

   logic               va_ff;
   logic               neg_a_ff, neg_a_in;
   logic [15:0]        mag_a_ff, mag_a_in;
   logic signed [16:0] clamped, absval;
   lane_type           lane_ff, lane_in;

   always_comb begin
      priority if (angle > ANGLE_LIMIT) begin
         clamped = ANGLE_LIMIT;
      end else if (angle < -ANGLE_LIMIT) begin
         clamped = -ANGLE_LIMIT;
      end else begin
         clamped = angle;
      end
      neg_a_in = clamped[16];
      absval   = neg_a_in ? -clamped : clamped;
      mag_a_in = absval[15:0];

      lane_in       = '0;
      lane_in.valid = va_ff;
      lane_in.neg   = neg_a_ff;
      lane_in.x     = 64'(mag_a_ff) * 64'(RAD_SCALE);
      lane_in.t     = ONE_Q52;
   end

   always_ff @(posedge clock) begin
      neg_a_ff <= neg_a_in;
      mag_a_ff <= mag_a_in;
      lane_ff  <= lane_in;
      if (reset) begin
         va_ff         <= 1'b0;
         lane_ff.valid <= 1'b0;
      end else begin
         va_ff <= accept;
      end
   end

   assign lane_o = lane_ff;

endmodule
`default_nettype wire

FILE: design/tsfu_term.sv
// One Taylor term: t_n = floor(floor(t_(n-1) * x / 2^52) / n), five stages,
// and the running sine and cosine sums. Depends on tsfu_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tsfu_term import tsfu_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [TERM_IDX_W-1:0] idx,
   input  logic [63:0]           recip,
   input  lane_type              lane_i,
   output lane_type              lane_o
);

   logic [TERM_IDX_W-1:0] prev_idx;
   lane_type              c1_ff, c2_ff, c3_ff, c4_ff, c5_ff, c1_in, c5_in;
   logic [63:0]           pa_ff [4];
   logic [63:0]           pa_in [4];
   logic [63:0]           pb_ff [4];
   logic [63:0]           pb_in [4];
   logic [63:0]           p2_ff, p2_in, p3_ff, p4_ff, qe4_ff, qe4_in;
   logic [127:0]          prod_a, prod_b;
   logic [63:0]           idx_ext, rem, quot;

   assign prev_idx = idx - 1'b1;

   always_comb begin
      c1_in    = accum(lane_i, prev_idx[1:0]);
      pa_in[0] = lane_i.t[31:0]  * lane_i.x[31:0];
      pa_in[1] = lane_i.t[31:0]  * lane_i.x[63:32];
      pa_in[2] = lane_i.t[63:32] * lane_i.x[31:0];
      pa_in[3] = lane_i.t[63:32] * lane_i.x[63:32];

      prod_a = {64'b0, pa_ff[0]} + {32'b0, pa_ff[1], 32'b0}
             + {32'b0, pa_ff[2], 32'b0} + {pa_ff[3], 64'b0};
      p2_in  = prod_a[FRAC_BITS+63:FRAC_BITS];

      pb_in[0] = p2_ff[31:0]  * recip[31:0];
      pb_in[1] = p2_ff[31:0]  * recip[63:32];
      pb_in[2] = p2_ff[63:32] * recip[31:0];
      pb_in[3] = p2_ff[63:32] * recip[63:32];

      prod_b = {64'b0, pb_ff[0]} + {32'b0, pb_ff[1], 32'b0}
             + {32'b0, pb_ff[2], 32'b0} + {pb_ff[3], 64'b0};
      qe4_in = prod_b[127:64];

      // estimate is low by at most one: fix with one compare
      idx_ext = 64'(idx);
      rem     = p4_ff - 64'(qe4_ff * idx_ext);
      quot    = (rem >= idx_ext) ? qe4_ff + 64'd1 : qe4_ff;
      c5_in   = c4_ff;
      c5_in.t = quot;
   end

   always_ff @(posedge clock) begin
      c1_ff  <= c1_in;
      pa_ff  <= pa_in;
      c2_ff  <= c1_ff;
      p2_ff  <= p2_in;
      c3_ff  <= c2_ff;
      p3_ff  <= p2_ff;
      pb_ff  <= pb_in;
      c4_ff  <= c3_ff;
      p4_ff  <= p3_ff;
      qe4_ff <= qe4_in;
      c5_ff  <= c5_in;
      if (reset) begin
         c1_ff.valid <= 1'b0;
         c2_ff.valid <= 1'b0;
         c3_ff.valid <= 1'b0;
         c4_ff.valid <= 1'b0;
         c5_ff.valid <= 1'b0;
      end
   end

   assign lane_o = c5_ff;

endmodule
`default_nettype wire

FILE: design/tsfu_div.sv
// Pipelined rounding divider: round(|num| * 2^16 / |den|) with sign and
// saturation, one quotient bit per stage. Depends on tsfu_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tsfu_div import tsfu_pkg::*; (
   input  logic               clock,
   input  logic signed [31:0] num,
   input  logic signed [31:0] den,
   output logic signed [31:0] quo,
   output logic               sat
);

   logic [30:0]          rem_ff  [DIV_STEPS+1];
   logic [DIV_STEPS-1:0] dd_ff   [DIV_STEPS+1];
   logic [DIV_STEPS-1:0] q_ff    [DIV_STEPS+1];
   logic [30:0]          ud_ff   [DIV_STEPS+1];
   logic                 neg_ff  [DIV_STEPS+1];
   logic                 nneg_ff [DIV_STEPS+1];
   logic                 zero_ff [DIV_STEPS+1];

   logic signed [31:0] un_s, ud_s, quo_ff, quo_in;
   logic [30:0]        mag;
   logic               over, sat_ff, sat_in;

   always_comb begin
      un_s = num[31] ? -num : num;
      ud_s = den[31] ? -den : den;
   end

   always_ff @(posedge clock) begin
      rem_ff[0]  <= '0;
      ud_ff[0]   <= ud_s[30:0];
      dd_ff[0]   <= {un_s[30:0], 16'b0} + DIV_STEPS'(ud_s[30:1]);
      q_ff[0]    <= '0;
      neg_ff[0]  <= num[31] ^ den[31];
      nneg_ff[0] <= num[31];
      zero_ff[0] <= (ud_s[30:0] == '0);
   end

   for (genvar i = 0; i < DIV_STEPS; i++) begin : g_step
      logic [31:0] trial, diff;
      logic        take;
      always_comb begin
         trial = {rem_ff[i], dd_ff[i][DIV_STEPS-1]};
         diff  = trial - {1'b0, ud_ff[i]};
         take  = (trial >= {1'b0, ud_ff[i]});
      end
      always_ff @(posedge clock) begin
         rem_ff[i+1]  <= take ? diff[30:0] : trial[30:0];
         dd_ff[i+1]   <= {dd_ff[i][DIV_STEPS-2:0], 1'b0};
         q_ff[i+1]    <= {q_ff[i][DIV_STEPS-2:0], take};
         ud_ff[i+1]   <= ud_ff[i];
         neg_ff[i+1]  <= neg_ff[i];
         nneg_ff[i+1] <= nneg_ff[i];
         zero_ff[i+1] <= zero_ff[i];
      end
   end

   always_comb begin
      over = (q_ff[DIV_STEPS][DIV_STEPS-1:31] != '0);
      mag  = over ? RATIO_MAX : q_ff[DIV_STEPS][30:0];
      priority if (zero_ff[DIV_STEPS]) begin
         quo_in = nneg_ff[DIV_STEPS] ? -$signed({1'b0, RATIO_MAX}) : $signed({1'b0, RATIO_MAX});
         sat_in = 1'b1;
      end else begin
         quo_in = neg_ff[DIV_STEPS] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
         sat_in = over;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      sat_ff <= sat_in;
   end

   assign quo = quo_ff;
   assign sat = sat_ff;

endmodule
`default_nettype wire

FILE: design/tsfu_ratio.sv
// Back end: last series term, rounding to Q2.30, the four ratio dividers
// and the result register. Depends on tsfu_pkg and tsfu_div.
`timescale 1ns / 1ps
`default_nettype none
module tsfu_ratio import tsfu_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  lane_type           lane_i,
   output logic               out_valid,
   output logic signed [31:0] out_sin,
   output logic signed [31:0] out_cos,
   output logic signed [31:0] out_tan,
   output logic signed [31:0] out_cot,
   output logic signed [31:0] out_csc,
   output logic signed [31:0] out_sec,
   output logic               out_sat
);

   lane_type           acc_ff, acc_in;
   logic               v1_ff;
   logic signed [31:0] sn_ff, sn_in, cs_ff, cs_in;
   logic [63:0]        abs_sin, abs_cos;
   logic [41:0]        m_sin, m_cos;
   logic [30:0]        c_sin, c_cos;
   logic               vd_ff [DIV_LAT];
   logic signed [31:0] snd_ff [DIV_LAT];
   logic signed [31:0] csd_ff [DIV_LAT];
   logic signed [31:0] tan_q, cot_q, csc_q, sec_q;
   logic               tan_s, cot_s, csc_s, sec_s;
   logic               ov_ff;
   logic signed [31:0] osin_ff, ocos_ff, otan_ff, ocot_ff, ocsc_ff, osec_ff;
   logic               osat_ff;

   always_comb begin
      acc_in  = accum(lane_i, 2'(TERM_COUNT));
      abs_sin = acc_ff.s_sin[63] ? 64'(-acc_ff.s_sin) : 64'(acc_ff.s_sin);
      abs_cos = acc_ff.s_cos[63] ? 64'(-acc_ff.s_cos) : 64'(acc_ff.s_cos);
      m_sin   = 42'((abs_sin + (64'd1 << (FRAC_BITS - 31))) >> (FRAC_BITS - 30));
      m_cos   = 42'((abs_cos + (64'd1 << (FRAC_BITS - 31))) >> (FRAC_BITS - 30));
      c_sin   = (m_sin > 42'(Q30_ONE)) ? 31'(Q30_ONE) : m_sin[30:0];
      c_cos   = (m_cos > 42'(Q30_ONE)) ? 31'(Q30_ONE) : m_cos[30:0];
      sn_in   = (acc_ff.s_sin[63] ^ acc_ff.neg) ? -$signed({1'b0, c_sin}) : $signed({1'b0, c_sin});
      cs_in   = acc_ff.s_cos[63] ? -$signed({1'b0, c_cos}) : $signed({1'b0, c_cos});
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      sn_ff  <= sn_in;
      cs_ff  <= cs_in;
      if (reset) begin
         acc_ff.valid <= 1'b0;
         v1_ff        <= 1'b0;
      end else begin
         v1_ff <= acc_ff.valid;
      end
   end

   tsfu_div u_tan (.clock(clock), .num(sn_ff),   .den(cs_ff), .quo(tan_q), .sat(tan_s));
   tsfu_div u_cot (.clock(clock), .num(cs_ff),   .den(sn_ff), .quo(cot_q), .sat(cot_s));
   tsfu_div u_csc (.clock(clock), .num(Q30_ONE), .den(sn_ff), .quo(csc_q), .sat(csc_s));
   tsfu_div u_sec (.clock(clock), .num(Q30_ONE), .den(cs_ff), .quo(sec_q), .sat(sec_s));

   always_ff @(posedge clock) begin
      snd_ff[0] <= sn_ff;
      csd_ff[0] <= cs_ff;
      for (int i = 1; i < DIV_LAT; i++) begin
         snd_ff[i] <= snd_ff[i-1];
         csd_ff[i] <= csd_ff[i-1];
      end
      if (reset) begin
         for (int i = 0; i < DIV_LAT; i++) begin
            vd_ff[i] <= 1'b0;
         end
      end else begin
         vd_ff[0] <= v1_ff;
         for (int i = 1; i < DIV_LAT; i++) begin
            vd_ff[i] <= vd_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      osin_ff <= snd_ff[DIV_LAT-1];
      ocos_ff <= csd_ff[DIV_LAT-1];
      otan_ff <= tan_q;
      ocot_ff <= cot_q;
      ocsc_ff <= csc_q;
      osec_ff <= sec_q;
      osat_ff <= tan_s | cot_s | csc_s | sec_s;
      if (reset) begin
         ov_ff <= 1'b0;
      end else begin
         ov_ff <= vd_ff[DIV_LAT-1];
      end
   end

   assign out_valid = ov_ff;
   assign out_sin   = osin_ff;
   assign out_cos   = ocos_ff;
   assign out_tan   = otan_ff;
   assign out_cot   = ocot_ff;
   assign out_csc   = ocsc_ff;
   assign out_sec   = osec_ff;
   assign out_sat   = osat_ff;

endmodule
`default_nettype wire

FILE: bench/trig_six_function_checker.sv
// Checker for the six-function trigonometry unit: watches the angle and
// result channels, predicts each result and compares it field by field.
// Depends on tsfu_pkg for widths and constants only.
`timescale 1ns / 1ps
module trig_six_function_checker import tsfu_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  logic signed [16:0] req_angle_deg,
   input  logic               rsp_valid,
   input  logic signed [31:0] rsp_sine_value,
   input  logic signed [31:0] rsp_cosine_value,
   input  logic signed [31:0] rsp_tangent_value,
   input  logic signed [31:0] rsp_cotangent_value,
   input  logic signed [31:0] rsp_cosecant_value,
   input  logic signed [31:0] rsp_secant_value,
   input  logic               rsp_ratio_status,
   output int                 fail_count,
   output int                 pending
);

   typedef struct {
      logic signed [31:0] sine;
      logic signed [31:0] cosine;
      logic signed [31:0] tangent;
      logic signed [31:0] cotangent;
      logic signed [31:0] cosecant;
      logic signed [31:0] secant;
      logic               status;
   } trig_result_type;

   trig_result_type expected_results[$];
   logic [63:0]     deg_to_rad;

   function automatic logic [63:0] scale_by_long_division();
      logic [63:0] den, rem, q;
      den = 64'd100000 * 64'd23040;
      rem = 64'd314159;
      q = 0;
      for (int i = 0; i < FRAC_BITS; i++) begin
         rem = rem << 1;
         q = q << 1;
         if (rem >= den) begin
            rem = rem - den;
            q[0] = 1'b1;
         end
      end
      return q;
   endfunction

   function automatic logic [63:0] fixed_mul(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      return p[115:52];
   endfunction

   function automatic logic signed [63:0] round_q30(input logic signed [63:0] s);
      logic [63:0] m;
      m = s[63] ? 64'(-s) : 64'(s);
      m = (m + (64'd1 << 21)) >> 22;
      if (m > 64'd1073741824) m = 64'd1073741824;
      return s[63] ? -$signed(m) : $signed(m);
   endfunction

   function automatic logic signed [31:0] sat_ratio(input logic signed [63:0] num,
                                                    input logic signed [63:0] den,
                                                    inout logic sat);
      logic        neg;
      logic [63:0] un, ud, q;
      neg = num[63] != den[63];
      un = num[63] ? 64'(-num) : 64'(num);
      ud = den[63] ? 64'(-den) : 64'(den);
      if (ud == 0) begin
         sat = 1'b1;
         return num[63] ? -32'sd2147483647 : 32'sd2147483647;
      end
      q = ((un << 16) + ud / 2) / ud;
      if (q > 64'd2147483647) begin
         sat = 1'b1;
         q = 64'd2147483647;
      end
      return neg ? -$signed(q[31:0]) : $signed(q[31:0]);
   endfunction

   function automatic trig_result_type predict_trig(input logic signed [16:0] angle);
      trig_result_type    r;
      logic signed [63:0] ang, s_sin, s_cos, sn, cs;
      logic [63:0]        x, t;
      logic               neg, sat;
      ang = angle;
      if (ang > 46080) ang = 46080;
      if (ang < -46080) ang = -46080;
      neg = ang < 0;
      x = 64'(neg ? -ang : ang) * deg_to_rad;
      t = 64'd1 << FRAC_BITS;
      s_sin = 0;
      s_cos = 64'sd1 << FRAC_BITS;
      for (int n = 1; n <= 2 * SERIES_TERMS + 1; n++) begin
         t = fixed_mul(t, x) / 64'(n);
         if (n % 2 == 1) begin
            if (((n - 1) / 2) % 2 == 1) s_sin = s_sin - $signed(t);
            else s_sin = s_sin + $signed(t);
         end else begin
            if ((n / 2) % 2 == 1) s_cos = s_cos - $signed(t);
            else s_cos = s_cos + $signed(t);
         end
      end
      sn = round_q30(s_sin);
      if (neg) sn = -sn;
      cs = round_q30(s_cos);
      sat = 1'b0;
      r.sine = sn[31:0];
      r.cosine = cs[31:0];
      r.tangent = sat_ratio(sn, cs, sat);
      r.cotangent = sat_ratio(cs, sn, sat);
      r.cosecant = sat_ratio(64'sd1073741824, sn, sat);
      r.secant = sat_ratio(64'sd1073741824, cs, sat);
      r.status = sat;
      return r;
   endfunction

   task automatic report_mismatch(input string field, input longint got, input longint want);
      $display("%0t: %s mismatch: got %0d expected %0d", $realtime, field, got, want);
      fail_count++;
   endtask

   initial begin
      fail_count = 0;
      pending = 0;
      deg_to_rad = scale_by_long_division();
   end

   always @(posedge clock) begin
      trig_result_type want;
      if (!reset && start && !busy) expected_results.push_back(predict_trig(req_angle_deg));
      if (!reset && rsp_valid) begin
         if (expected_results.size() == 0) begin
            $display("%0t: result beat with nothing outstanding", $realtime);
            fail_count++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_sine_value !== want.sine)
               report_mismatch("sine", rsp_sine_value, want.sine);
            if (rsp_cosine_value !== want.cosine)
               report_mismatch("cosine", rsp_cosine_value, want.cosine);
            if (rsp_tangent_value !== want.tangent)
               report_mismatch("tangent", rsp_tangent_value, want.tangent);
            if (rsp_cotangent_value !== want.cotangent)
               report_mismatch("cotangent", rsp_cotangent_value, want.cotangent);
            if (rsp_cosecant_value !== want.cosecant)
               report_mismatch("cosecant", rsp_cosecant_value, want.cosecant);
            if (rsp_secant_value !== want.secant)
               report_mismatch("secant", rsp_secant_value, want.secant);
            if (rsp_ratio_status !== want.status)
               report_mismatch("ratio_status", rsp_ratio_status, want.status);
         end
      end
      pending <= expected_results.size();
   end

endmodule

FILE: bench/testbench.sv
// Top of the trigonometry unit bench: clock, reset, angle stimulus, watchdog
// and verdict. Depends on tsfu_pkg, trig_six_function_unit_top and the checker.
`timescale 1ns / 1ps
module testbench;
   import tsfu_pkg::*;

   localparam int IDLE_LIMIT = 5000;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic signed [16:0] req_angle_deg = '0;
   logic               busy, rsp_valid, rsp_ratio_status;
   logic signed [31:0] rsp_sine_value, rsp_cosine_value, rsp_tangent_value;
   logic signed [31:0] rsp_cotangent_value, rsp_cosecant_value, rsp_secant_value;
   int                 fail_count, pending, quiet_cycles;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   trig_six_function_unit_top u_top (.*);
   trig_six_function_checker u_checker (.*);

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task automatic send_angle(input logic signed [16:0] angle, input int idle_pct);
      logic held;
      if ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      start <= 1'b1;
      req_angle_deg <= angle;
      do begin
         @(negedge clock);
         held = busy;
         @(posedge clock);
      end while (held);
   endtask

   function automatic logic signed [16:0] random_angle();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 80) return 17'($signed($urandom_range(0, 92160)) - 46080);
      if (pick < 90)
         return 17'($signed($urandom_range(0, 16)) * 2880 - 23040 * 2
                    + $signed($urandom_range(0, 6)) - 3);
      return 17'($urandom);
   endfunction

   logic signed [16:0] directed_angles[] = '{
      17'sd0, 17'sd1, -17'sd1, 17'sd46080, -17'sd46080, 17'sd46081, -17'sd46081,
      17'sd65535, -17'sd65536, 17'sd11520, -17'sd11520, 17'sd23040, -17'sd23040,
      17'sd34560, -17'sd34560, 17'sd5760, 17'sd17280, -17'sd28800, 17'sd11519,
      17'sd23041, 17'sd40320, 17'sd43690, -17'sd21845};

   initial begin
      int idle_pct;
      quiet_cycles = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      foreach (directed_angles[i]) send_angle(directed_angles[i], 0);
      for (int phase = 0; phase < 3; phase++) begin
         idle_pct = (phase == 0) ? 13 : (phase == 1) ? 65 : 0;
         repeat (560) send_angle(random_angle(), idle_pct);
      end
      start <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (310) @(posedge clock);
      if (fail_count == 0) $display("[ OK ] regression clean");
      else $display("[FAIL] regression broken");
      $finish;
   end

endmodule

FILE: filelist.f
design/tsfu_pkg.sv
design/tsfu_front.sv
design/tsfu_term.sv
design/tsfu_div.sv
design/tsfu_ratio.sv
design/trig_six_function_unit_top.sv
bench/trig_six_function_checker.sv
bench/testbench.sv
